FILE: src/dsc_pkg.sv
`default_nettype none

package dsc_pkg;

   // half-steps run per check pass
   localparam int STEPS_PER_CHECK = 8;
   // step counter width, never below one bit
   localparam int STEP_W = (STEPS_PER_CHECK > 1) ? $clog2(STEPS_PER_CHECK) : 1;

   localparam int CSR_INDEX_W = 2;
   localparam int THRESH_W    = 10;

   localparam logic [CSR_INDEX_W-1:0] CSR_OPEN_THRESH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLOSE_THRESH = 2'd1;

   localparam logic [THRESH_W-1:0] OPEN_THRESH_RESET  = 10'd500;
   localparam logic [THRESH_W-1:0] CLOSE_THRESH_RESET = 10'd950;

   // command bit that toggles the wanted direction
   localparam int CMD_TOGGLE_BIT = 1;

   typedef struct packed {
      logic                command_valid;
      logic [7:0]          command_byte;
      logic [THRESH_W-1:0] light_level;
   } req_payload_type;

   typedef struct packed {
      logic [3:0] coil_pattern;
      logic       stepping;
      logic       drawer_out;
   } rsp_payload_type;

   typedef struct packed {
      logic [THRESH_W-1:0] open_thresh;
      logic [THRESH_W-1:0] close_thresh;
   } thresh_type;

   // half-step coil patterns: forward (drawer in) and reverse (drawer out)
   function automatic logic [3:0] coil_lookup(input logic dir_out, input logic [2:0] idx);
      logic [3:0] pat;
      case (idx)
         3'd0:    pat = 4'h1;
         3'd1:    pat = 4'h3;
         3'd2:    pat = 4'h2;
         3'd3:    pat = 4'h6;
         3'd4:    pat = 4'h4;
         3'd5:    pat = 4'hc;
         3'd6:    pat = 4'h8;
         default: pat = 4'h9;
      endcase
      if (dir_out) begin
         case (idx)
            3'd0:    pat = 4'h9;
            3'd1:    pat = 4'h8;
            3'd2:    pat = 4'hc;
            3'd3:    pat = 4'h4;
            3'd4:    pat = 4'h6;
            3'd5:    pat = 4'h2;
            3'd6:    pat = 4'h3;
            default: pat = 4'h1;
         endcase
      end
      return pat;
   endfunction

endpackage

`default_nettype wire

FILE: src/dsc_fsm.sv
`default_nettype none

module dsc_fsm (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    advance,
   input  wire dsc_pkg::req_payload_type req,
   input  wire dsc_pkg::thresh_type     thresh,
   output dsc_pkg::rsp_payload_type     result
);
   import dsc_pkg::*;

   localparam logic [1:0] PH_INIT  = 2'd0;
   localparam logic [1:0] PH_CHECK = 2'd1;
   localparam logic [1:0] PH_STEP  = 2'd2;

   logic [1:0]        phase_ff, phase_in;
   logic              wanted_ff, wanted_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [3:0]        coil_ff, coil_in;
   logic              stepping;
   logic              wanted_tog;
   logic [STEP_W:0]   step_next;

   assign wanted_tog = wanted_ff ^ (req.command_valid & req.command_byte[CMD_TOGGLE_BIT]);
   assign step_next  = {1'b0, step_ff} + (STEP_W+1)'(1);

   always_comb begin
      phase_in  = phase_ff;
      wanted_in = wanted_tog;
      step_in   = step_ff;
      coil_in   = coil_ff;
      stepping  = 1'b0;
      unique case (phase_ff)
         PH_CHECK: begin
            if ((wanted_tog && (req.light_level > thresh.open_thresh)) ||
                (!wanted_tog && (req.light_level < thresh.close_thresh))) begin
               step_in  = '0;
               phase_in = PH_STEP;
            end
         end
         PH_STEP: begin
            coil_in  = coil_lookup(wanted_tog, 3'(step_ff));
            stepping = 1'b1;
            if (step_next >= (STEP_W+1)'(STEPS_PER_CHECK)) begin
               step_in  = '0;
               phase_in = PH_CHECK;
            end else begin
               step_in = step_next[STEP_W-1:0];
            end
         end
         default: begin
            // init, and the unused code
            wanted_in = 1'b0;
            step_in   = '0;
            phase_in  = PH_CHECK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_INIT;
         wanted_ff <= 1'b0;
         step_ff   <= '0;
         coil_ff   <= '0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         wanted_ff <= wanted_in;
         step_ff   <= step_in;
         coil_ff   <= coil_in;
      end
   end

   assign result.coil_pattern = coil_in;
   assign result.stepping     = stepping;
   assign result.drawer_out   = wanted_in;

endmodule

`default_nettype wire

FILE: src/drawer_stepper_controller_unit.sv
`default_nettype none

// Drawer stepper controller. Each request is one controller tick: an optional
// command byte (bit 1 toggles the wanted drawer direction) and a light level.
// The controller runs init, check and step phases; from check it starts a run
// of half-steps when the light is above the open threshold with out wanted, or
// below the close threshold with in wanted. Every request yields exactly one
// response with the held coil pattern, a stepping flag and the direction.
// Rate: one request per cycle; the tick logic sits between the state
// registers and the response register, which frees as it is taken, so
// requests keep flowing while rsp_stall is low. Thresholds are written
// through the csr port (index 0 open, 1 close); the user must write them only
// while idle, unenforced; csr_ready is always high, unknown indexes dropped.

module drawer_stepper_controller_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire dsc_pkg::req_payload_type             req_payload,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output dsc_pkg::rsp_payload_type                  rsp_payload,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [dsc_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [dsc_pkg::THRESH_W-1:0]         csr_data
);
   import dsc_pkg::*;

   thresh_type      thresh_ff;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_payload_ff;
   rsp_payload_type tick_result;
   logic            accept;

   assign csr_ready = 1'b1;

   // threshold registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff.open_thresh  <= OPEN_THRESH_RESET;
         thresh_ff.close_thresh <= CLOSE_THRESH_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_OPEN_THRESH:  thresh_ff.open_thresh  <= csr_data;
            CSR_CLOSE_THRESH: thresh_ff.close_thresh <= csr_data;
            default: ;
         endcase
      end
   end

   // stall only while a response waits and the far side holds it
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   dsc_fsm u_fsm (
      .clock   (clock),
      .reset   (reset),
      .advance (accept),
      .req     (req_payload),
      .thresh  (thresh_ff),
      .result  (tick_result)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         rsp_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_payload_ff <= tick_result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

FILE: src/dsc_checker.sv
`default_nettype none

module dsc_checker (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     req_valid,
   input wire logic                     req_stall,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_stall,
   input wire dsc_pkg::rsp_payload_type rsp_payload
);
   import dsc_pkg::*;

   // held response stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("response changed while stalled");

   // every accepted request gives a response next cycle
   a_req_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted request produced no response");

   // an empty output never stalls the requester
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("request stalled with empty output");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind drawer_stepper_controller_unit dsc_checker u_dsc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

`default_nettype wire

FILE: test/drawer_stepper_controller_unit_test.sv
module drawer_stepper_controller_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import dsc_pkg::*;

   // Controller phase codes as the checker tracks them.
   localparam logic [1:0] PH_INIT  = 2'd0;
   localparam logic [1:0] PH_CHECK = 2'd1;
   localparam logic [1:0] PH_STEP  = 2'd2;

   // Index 3 is not decoded by the block; writes to it must be dropped.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   // Half-step coil patterns, nibble i holds step i.
   // Forward (drawer in):   1 3 2 6 4 c 8 9
   // Reverse (drawer out):  9 8 c 4 6 2 3 1
   localparam logic [31:0] FWD_COILS = 32'h98c4_6231;
   localparam logic [31:0] REV_COILS = 32'h1326_4c89;

   localparam int PHASE_ITEMS = 180;

   // One row of the directed table. When known is set the response is the
   // one typed here; otherwise it comes from the tick predictor.
   typedef struct packed {
      req_payload_type req;
      logic            known;
      rsp_payload_type rsp;
   } dir_row_type;

   localparam dir_row_type DIR_ROWS [23] = '{
      // toggle during the init tick is lost
      '{'{1'b1, 8'hff, 10'd0},    1'b1, '{4'h0, 1'b0, 1'b0}},
      // in wanted, full light: no run
      '{'{1'b0, 8'h00, 10'd1023}, 1'b1, '{4'h0, 1'b0, 1'b0}},
      // command without bit 1; light equal to close threshold: no run
      '{'{1'b1, 8'hfd, 10'd950},  1'b1, '{4'h0, 1'b0, 1'b0}},
      // bit 1 set but no valid command; dark starts a forward run
      '{'{1'b0, 8'h02, 10'd0},    1'b1, '{4'h0, 1'b0, 1'b0}},
      '{'{1'b0, 8'h00, 10'd1023}, 1'b1, '{4'h1, 1'b1, 1'b0}},
      '{'{1'b1, 8'hfd, 10'd512},  1'b1, '{4'h3, 1'b1, 1'b0}},
      '{'{1'b0, 8'hff, 10'd0},    1'b1, '{4'h2, 1'b1, 1'b0}},
      '{'{1'b0, 8'h00, 10'd700},  1'b1, '{4'h6, 1'b1, 1'b0}},
      '{'{1'b0, 8'h00, 10'd1},    1'b1, '{4'h4, 1'b1, 1'b0}},
      '{'{1'b0, 8'h00, 10'd1022}, 1'b1, '{4'hc, 1'b1, 1'b0}},
      '{'{1'b0, 8'h00, 10'd0},    1'b1, '{4'h8, 1'b1, 1'b0}},
      '{'{1'b0, 8'h00, 10'd1023}, 1'b1, '{4'h9, 1'b1, 1'b0}},
      // toggle to out; light equal to open threshold: no run, coils held
      '{'{1'b1, 8'h02, 10'd500},  1'b1, '{4'h9, 1'b0, 1'b1}},
      '{'{1'b0, 8'h00, 10'd501},  1'b1, '{4'h9, 1'b0, 1'b1}},
      '{'{1'b0, 8'h00, 10'd0},    1'b1, '{4'h9, 1'b1, 1'b1}},
      '{'{1'b0, 8'h00, 10'd0},    1'b1, '{4'h8, 1'b1, 1'b1}},
      // direction flips mid-run: rest of the run uses the forward table
      '{'{1'b1, 8'h02, 10'd0},    1'b0, '{4'h0, 1'b0, 1'b0}},
      '{'{1'b0, 8'h00, 10'd1023}, 1'b0, '{4'h0, 1'b0, 1'b0}},
      '{'{1'b0, 8'haa, 10'd0},    1'b0, '{4'h0, 1'b0, 1'b0}},
      '{'{1'b1, 8'h55, 10'd0},    1'b0, '{4'h0, 1'b0, 1'b0}},
      '{'{1'b0, 8'h00, 10'd0},    1'b0, '{4'h0, 1'b0, 1'b0}},
      '{'{1'b0, 8'h00, 10'd0},    1'b0, '{4'h0, 1'b0, 1'b0}},
      // just below close threshold with in wanted: new run
      '{'{1'b0, 8'h00, 10'd949},  1'b0, '{4'h0, 1'b0, 1'b0}}
   };

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_payload_type        req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_payload_type        rsp_payload;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [THRESH_W-1:0]    csr_data = '0;

   // Typed response for the request currently on the bus (directed rows).
   logic                   pin_en = 1'b0;
   rsp_payload_type        pin_rsp = '0;

   // Idling switches, flipped in stretches so some runs go back to back.
   logic                   gaps_on = 1'b1;
   logic                   stalls_on = 1'b1;

   // Predictor state: mirrors the controller registers.
   logic [1:0]             tick_phase;
   logic                   dir_out;
   int                     step_cnt;
   logic [3:0]             coil_held;
   logic [THRESH_W-1:0]    open_thr;
   logic [THRESH_W-1:0]    close_thr;

   rsp_payload_type        pending_rsps [$];
   int                     errors = 0;
   int                     req_count = 0;
   int                     step_count = 0;
   int                     turn_count = 0;
   int                     setting_count = 0;

   drawer_stepper_controller_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // One controller tick: command first, then the phase logic on the new
   // direction. Returns the response the block must give for this request.
   function automatic rsp_payload_type predict_tick(input req_payload_type r);
      rsp_payload_type o;
      logic            was_out;
      was_out = dir_out;
      o.stepping = 1'b0;
      if (r.command_valid && r.command_byte[CMD_TOGGLE_BIT])
         dir_out = ~dir_out;
      case (tick_phase)
         PH_CHECK: begin
            if ((dir_out && r.light_level > open_thr) ||
                (!dir_out && r.light_level < close_thr)) begin
               step_cnt = 0;
               tick_phase = PH_STEP;
            end
         end
         PH_STEP: begin
            // table index wraps on the low three bits of the count
            coil_held = dir_out ? REV_COILS[4*(step_cnt % 8) +: 4]
                                : FWD_COILS[4*(step_cnt % 8) +: 4];
            o.stepping = 1'b1;
            step_cnt++;
            step_count++;
            if (step_cnt >= STEPS_PER_CHECK) begin
               step_cnt = 0;
               tick_phase = PH_CHECK;
            end
         end
         default: begin
            // init (and the unused code) clears the direction
            dir_out = 1'b0;
            step_cnt = 0;
            tick_phase = PH_CHECK;
         end
      endcase
      if (dir_out != was_out)
         turn_count++;
      o.coil_pattern = coil_held;
      o.drawer_out = dir_out;
      return o;
   endfunction

   // Response check first, then prediction for a request taken at this edge.
   // Both sample pre-edge values, so process order within the step is moot.
   always @(posedge clock) begin : rsp_check
      rsp_payload_type want;
      rsp_payload_type pred;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_rsps.size() == 0) begin
               $display("%0t: response %h with no request outstanding", $time, rsp_payload);
               errors++;
            end else begin
               want = pending_rsps.pop_front();
               if (rsp_payload.coil_pattern !== want.coil_pattern) begin
                  $display("%0t: coil_pattern expected %h actual %h", $time,
                           want.coil_pattern, rsp_payload.coil_pattern);
                  errors++;
               end
               if (rsp_payload.stepping !== want.stepping) begin
                  $display("%0t: stepping expected %b actual %b", $time,
                           want.stepping, rsp_payload.stepping);
                  errors++;
               end
               if (rsp_payload.drawer_out !== want.drawer_out) begin
                  $display("%0t: drawer_out expected %b actual %b", $time,
                           want.drawer_out, rsp_payload.drawer_out);
                  errors++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            pred = predict_tick(req_payload);
            pending_rsps.push_back(pin_en ? pin_rsp : pred);
            req_count++;
         end
      end
   end

   // Response side back-pressure: a fresh stall draw for every response.
   initial begin : rsp_stall_drive
      int hold;
      wait (reset == 1'b0);
      forever begin
         hold = stalls_on ? $urandom_range(0, 10) : 0;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   // Present one request after a random gap and hold it until taken.
   // valid stays high across back-to-back requests (no drop in the same step).
   task automatic send_tick(input req_payload_type r, input logic pin,
                            input rsp_payload_type pinned);
      int gap;
      gap = gaps_on ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      pin_en <= pin;
      pin_rsp <= pinned;
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   // Stop sending and wait until every outstanding response is back, then
   // let the response register settle. The negedge lets the checker log
   // the request taken at this edge before the queue is looked at.
   task automatic drain_requests();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_rsps.size() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // Program both thresholds, plus a write to the undecoded index that must
   // leave them alone. Only called with the block idle.
   task automatic apply_thresholds(input logic [THRESH_W-1:0] open_val,
                                   input logic [THRESH_W-1:0] close_val);
      csr_valid <= 1'b1;
      csr_index <= CSR_OPEN_THRESH;
      csr_data <= open_val;
      do @(posedge clock); while (!csr_ready);
      open_thr = open_val;
      csr_index <= CSR_CLOSE_THRESH;
      csr_data <= close_val;
      do @(posedge clock); while (!csr_ready);
      close_thr = close_val;
      csr_index <= CSR_UNUSED;
      csr_data <= THRESH_W'($urandom_range(0, 1023));
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      setting_count++;
   endtask

   initial begin : stimulus
      req_payload_type r;
      logic [THRESH_W-1:0] open_val;
      logic [THRESH_W-1:0] close_val;
      int sel;

      tick_phase = PH_INIT;
      dir_out = 1'b0;
      step_cnt = 0;
      coil_held = 4'h0;
      open_thr = OPEN_THRESH_RESET;
      close_thr = CLOSE_THRESH_RESET;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset thresholds, boundary lights, mid-run direction flip.
      for (int k = 0; k < $size(DIR_ROWS); k++)
         send_tick(DIR_ROWS[k].req, DIR_ROWS[k].known, DIR_ROWS[k].rsp);

      // Random phases: threshold extremes first, then random settings.
      for (int p = 0; p < 7; p++) begin
         case (p)
            0:       begin open_val = '1; close_val = '0; end  // never starts a run
            1:       begin open_val = '0; close_val = '1; end  // nearly always runs
            2:       begin open_val = '0; close_val = '0; end
            3:       begin open_val = '1; close_val = '1; end
            default: begin
               open_val = THRESH_W'($urandom_range(0, 1023));
               close_val = THRESH_W'($urandom_range(0, 1023));
            end
         endcase
         drain_requests();
         apply_thresholds(open_val, close_val);

         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (i % 40 == 0) begin
               gaps_on = ($urandom_range(0, 2) != 0);
               stalls_on = ($urandom_range(0, 2) != 0);
            end
            // now and then let the pipeline run dry mid-phase
            if ($urandom_range(0, 99) == 0)
               drain_requests();

            // ~10% toggles, ~20% commands without bit 1, rest no command
            sel = $urandom_range(0, 9);
            r.command_byte = 8'($urandom_range(0, 255));
            r.command_valid = (sel <= 2);
            if (sel == 0)
               r.command_byte[CMD_TOGGLE_BIT] = 1'b1;
            else if (sel <= 2)
               r.command_byte[CMD_TOGGLE_BIT] = 1'b0;

            // light biased toward the thresholds and the range ends
            case ($urandom_range(0, 7))
               0:       r.light_level = '0;
               1:       r.light_level = '1;
               2:       r.light_level = THRESH_W'(open_thr + $urandom_range(0, 2) - 1);
               3:       r.light_level = THRESH_W'(close_thr + $urandom_range(0, 2) - 1);
               default: r.light_level = THRESH_W'($urandom_range(0, 1023));
            endcase
            send_tick(r, 1'b0, '0);
         end
      end

      // Wind down: wait for the tail of responses, bounded.
      req_valid <= 1'b0;
      @(negedge clock);
      for (int w = 0; w < 2000 && pending_rsps.size() != 0; w++)
         @(posedge clock);
      repeat (4) @(posedge clock);
      if (pending_rsps.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, pending_rsps.size());
         errors++;
      end

      $display("Covered %0d requests, %0d coil steps, %0d direction changes",
               req_count, step_count, turn_count);
      $display("across %0d threshold settings after the reset values", setting_count);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Hard stop if the handshake hangs.
   initial begin : watchdog
      #2_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
